[sv/bist_pkg.sv]
// Package for the skeleton thinning block: shared types, codes and the
// Zhang-Suen neighborhood test. No dependencies.
package bist_pkg;

	localparam int ACT_W = 2;
	localparam int CNT_W = 16;
	localparam int DIM_W = 9;

	typedef enum logic [ACT_W-1:0] {
		ACT_WRITE = 2'd0,
		ACT_THIN  = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	localparam logic [0:0] REG_WIDTH  = 1'd0;
	localparam logic [0:0] REG_HEIGHT = 1'd1;

	// Controller to datapath commands
	typedef struct packed {
		logic clr_img;     // image store clear sweep step
		logic load_req;    // latch request fields
		logic host_wr;     // host pixel write
		logic host_rd;     // host pixel read issue
		logic rd_cap;      // capture read data into result
		logic thin_start;  // reset iteration count
		logic iter_start;  // clear changed flag
		logic judge;       // one judge step
		logic judge_init;  // reset scan position
		logic apply;       // one apply step
		logic iter_done;   // count iteration
		logic phase;       // sub-pass select
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clr_last;
		logic scan_last;
		logic changed;
		logic tiny;
	} sts_t;

	// Zhang-Suen mark test; n[0]=P2 ... n[7]=P9
	function automatic logic zs_mark(input logic p1, input logic [7:0] n,
			input logic phase);
		logic [3:0] b;
		logic [3:0] a;
		logic m1, m2;
		b = '0;
		a = '0;
		for (int k = 0; k < 8; k++) begin
			b = b + 4'(n[k]);
			a = a + 4'(!n[k] && n[(k + 1) % 8]);
		end
		if (!phase) begin
			m1 = n[0] & n[2] & n[4];
			m2 = n[2] & n[4] & n[6];
		end else begin
			m1 = n[0] & n[2] & n[6];
			m2 = n[0] & n[4] & n[6];
		end
		return p1 && (a == 4'd1) && (b >= 4'd2) && (b <= 4'd6) && !m1 && !m2;
	endfunction

endpackage

[sv/bist_if.sv]
// Valid/ready channel interfaces for the thinning block.
// No dependencies.
interface bist_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] row;
	logic [7:0] col;
	logic       pixel_in;
	modport source (output valid, action, row, col, pixel_in, input ready);
	modport sink (input valid, action, row, col, pixel_in, output ready);
endinterface

interface bist_rsp_if;
	logic        valid;
	logic        ready;
	logic        pixel_out;
	logic [15:0] iterations;
	modport source (output valid, pixel_out, iterations, input ready);
	modport sink (input valid, pixel_out, iterations, output ready);
endinterface

[sv/bist_ram.sv]
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module bist_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[sv/bist_ctrl.sv]
// Controller state machine of the thinning block: handshake, clear sweep,
// sub-pass sequencing. Depends on bist_pkg.
module bist_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [1:0]      in_action,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  bist_pkg::sts_t  sts,
	output bist_pkg::cmd_t  cmd
);
	import bist_pkg::*;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b000_0001,
		S_IDLE  = 7'b000_0010,
		S_RD    = 7'b000_0100,
		S_JUDGE = 7'b000_1000,
		S_APPLY = 7'b001_0000,
		S_ITER  = 7'b010_0000,
		S_DRAIN = 7'b100_0000
	} state_t;

	state_t state_q, state_d;
	logic   phase_q, phase_d;
	logic   ov_q, ov_d;
	logic   acc;

	// Output register frees when taken
	assign out_valid = ov_q;
	assign in_ready  = (state_q == S_IDLE) && (!ov_q || out_ready);
	assign acc       = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		ov_d    = ov_q && !out_ready;
		cmd     = '0;
		cmd.phase = phase_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_img = 1'b1;
				if (sts.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (acc) begin
					cmd.load_req = 1'b1;
					unique case (action_t'(in_action))
						ACT_WRITE: begin
							cmd.host_wr = 1'b1;
							ov_d = 1'b1;
						end
						ACT_READ: begin
							cmd.host_rd = 1'b1;
							state_d = S_RD;
						end
						ACT_THIN: begin
							cmd.thin_start = 1'b1;
							cmd.iter_start = 1'b1;
							cmd.judge_init = 1'b1;
							phase_d = 1'b0;
							state_d = S_JUDGE;
						end
						default: ov_d = 1'b1;
					endcase
				end
			end
			// read data is on the RAM output now
			S_RD: begin
				cmd.rd_cap = 1'b1;
				ov_d = 1'b1;
				state_d = S_IDLE;
			end
			S_JUDGE: begin
				if (sts.tiny) begin
					state_d = S_ITER;
				end else begin
					cmd.judge = 1'b1;
					if (sts.scan_last) begin
						cmd.judge_init = 1'b1;
						state_d = S_DRAIN;
					end
				end
			end
			S_DRAIN: begin
				// last mark write lands before apply reads
				cmd.apply = 1'b0;
				state_d = S_APPLY;
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				if (sts.scan_last) begin
					cmd.judge_init = 1'b1;
					if (phase_q) begin
						state_d = S_ITER;
					end else begin
						phase_d = 1'b1;
						state_d = S_JUDGE;
					end
				end
			end
			S_ITER: begin
				cmd.iter_done = 1'b1;
				phase_d = 1'b0;
				cmd.judge_init = 1'b1;
				if (sts.changed && !sts.tiny) begin
					cmd.iter_start = 1'b1;
					state_d = S_JUDGE;
				end else begin
					ov_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			phase_q <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			ov_q    <= ov_d;
		end
	end
endmodule

[sv/bist_dp.sv]
// Datapath of the thinning block: image and mark RAMs, scan counters,
// 3x3 window registers and the result register. Depends on bist_pkg, bist_ram.
module bist_dp #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [0:0]                cfg_index,
	input  logic [bist_pkg::DIM_W-1:0] cfg_data,
	input  logic [7:0]                row,
	input  logic [7:0]                col,
	input  logic                      pixel_in,
	input  bist_pkg::cmd_t            cmd,
	output bist_pkg::sts_t            sts,
	output logic                      pixel_out,
	output logic [bist_pkg::CNT_W-1:0] iterations
);
	import bist_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int AW = CW + RW;
	localparam int DEPTH = 1 << AW;
	localparam int XW = CW + 1;
	localparam int YW = RW + 1;

	logic [DIM_W-1:0] w_cfg_q, h_cfg_q;
	logic [XW-1:0]    w_use;
	logic [YW-1:0]    h_use;
	logic             inside_q, rd_ok_q;
	logic             out_pix_q;
	logic [CNT_W-1:0] iter_q;
	logic             changed_q;
	logic [AW-1:0]    clr_q;

	// Scan position and per-pixel read sequencing: reading P1 and eight neighbors,
	// then writing the mark.
	logic [CW-1:0]    x_q;
	logic [RW-1:0]    y_q;
	logic [3:0]       ph_q;
	logic [7:0]       nb_q;
	logic             p1_q;

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_cfg_q <= 9'd256;
			h_cfg_q <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  w_cfg_q <= cfg_data;
				REG_HEIGHT: h_cfg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign w_use = (32'(w_cfg_q) > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(w_cfg_q);
	assign h_use = (32'(h_cfg_q) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(h_cfg_q);
	assign sts.tiny = (w_use < XW'(3)) || (h_use < YW'(3));

	// Neighbor offsets per sequence step: 0=P1, 1..8 = P2..P9
	logic signed [1:0] dy, dx;
	always_comb begin
		unique case (ph_q)
			4'd1: begin dy = -2'sd1; dx = 2'sd0;  end
			4'd2: begin dy = -2'sd1; dx = 2'sd1;  end
			4'd3: begin dy = 2'sd0;  dx = 2'sd1;  end
			4'd4: begin dy = 2'sd1;  dx = 2'sd1;  end
			4'd5: begin dy = 2'sd1;  dx = 2'sd0;  end
			4'd6: begin dy = 2'sd1;  dx = -2'sd1; end
			4'd7: begin dy = 2'sd0;  dx = -2'sd1; end
			4'd8: begin dy = -2'sd1; dx = -2'sd1; end
			default: begin dy = 2'sd0; dx = 2'sd0; end
		endcase
	end

	logic [CW-1:0] nx;
	logic [RW-1:0] ny;
	assign nx = x_q + CW'(dx);
	assign ny = y_q + RW'(dy);

	// Image RAM port muxing
	logic          img_we, img_wd, img_rd;
	logic [AW-1:0] img_wa, img_ra, cur_a;
	logic          mk_we, mk_wd, mk_rd;
	logic [AW-1:0] host_a;
	logic          inside_ok;

	assign host_a = {RW'(row), CW'(col)};
	assign cur_a  = {y_q, x_q};
	assign inside_ok = (32'(row) < MAX_HEIGHT) && (32'(col) < MAX_WIDTH);

	// Apply sequence: ph 0 read mark, ph 1 write; mark known at ph 1.
	// Judge: P9 is still on the RAM output when the mark is written.
	always_comb begin
		img_we = 1'b0;
		img_wd = 1'b0;
		img_wa = host_a;
		img_ra = host_a;
		mk_we  = 1'b0;
		mk_wd  = zs_mark(p1_q, {img_rd, nb_q[6:0]}, cmd.phase);
		if (cmd.clr_img) begin
			img_we = 1'b1;
			img_wa = clr_q;
		end else if (cmd.host_wr) begin
			img_we = inside_ok;
			img_wd = pixel_in;
		end else if (cmd.judge) begin
			img_ra = {ny, nx};
			mk_we  = (ph_q == 4'd9);
		end else if (cmd.apply) begin
			img_wa = cur_a;
			img_we = (ph_q == 4'd1) && mk_rd;
		end
	end

	bist_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_img (
		.clk(clk), .we(img_we), .waddr(img_wa), .wdata(img_wd),
		.raddr(img_ra), .rdata(img_rd)
	);

	bist_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_mark (
		.clk(clk), .we(mk_we), .waddr(cur_a), .wdata(mk_wd),
		.raddr(cur_a), .rdata(mk_rd)
	);

	// Step end: ph 9 for judge (issue 0..8, capture 1..9), ph 1 for apply
	logic step_end;
	assign step_end = cmd.judge ? (ph_q == 4'd9) : (ph_q == 4'd1);
	logic x_last, y_last;
	assign x_last = (XW'(x_q) == w_use - XW'(2));
	assign y_last = (YW'(y_q) == h_use - YW'(2));
	assign sts.scan_last = (cmd.judge || cmd.apply) && step_end && x_last && y_last;
	assign sts.clr_last  = (clr_q == AW'(DEPTH - 1));
	assign sts.changed   = changed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= CW'(1); y_q <= RW'(1); ph_q <= '0;
			clr_q <= '0; changed_q <= 1'b0; iter_q <= '0;
		end else begin
			if (cmd.clr_img)
				clr_q <= clr_q + AW'(1);
			if (cmd.judge_init) begin
				x_q <= CW'(1); y_q <= RW'(1); ph_q <= '0;
			end else if (cmd.judge || cmd.apply) begin
				if (step_end) begin
					ph_q <= '0;
					if (x_last) begin
						x_q <= CW'(1);
						y_q <= y_q + RW'(1);
					end else begin
						x_q <= x_q + CW'(1);
					end
				end else begin
					ph_q <= ph_q + 4'd1;
				end
			end
			if (cmd.thin_start)
				iter_q <= '0;
			else if (cmd.iter_done && iter_q != '1)
				iter_q <= iter_q + CNT_W'(1);
			if (cmd.iter_start)
				changed_q <= 1'b0;
			else if (img_we && cmd.apply)
				changed_q <= 1'b1;
		end
	end

	// Window capture: read data arrives in the cycle after issue
	always_ff @(posedge clk) begin
		if (cmd.judge) begin
			if (ph_q == 4'd1)
				p1_q <= img_rd;
			else if (ph_q != 4'd0)
				nb_q[3'(ph_q - 4'd2)] <= img_rd;
		end
	end

	// Host request and result
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			inside_q  <= inside_ok;
			out_pix_q <= 1'b0;
		end
		if (cmd.host_rd)
			rd_ok_q <= inside_ok;
		if (cmd.rd_cap)
			out_pix_q <= rd_ok_q & img_rd;
	end

	assign pixel_out  = out_pix_q & inside_q;
	assign iterations = iter_q;
endmodule

[sv/binary_image_skeleton_thinning.sv]
// Zhang-Suen thinning block, top level. Depends on bist_pkg, bist_if,
// bist_ctrl, bist_dp.
// Write: answered from idle. Read: passes through S_RD for the registered RAM read.
// Thin: per iteration, a judge scan and an apply scan per sub-pass over the interior
// pixels, with the 3x3 window fetched through the single image RAM read port.
// After reset a clearing pass over all 2**(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) addresses
// zeroes the image; no request is accepted meanwhile. Config writes are always taken.
module binary_image_skeleton_thinning #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [8:0] cfg_data,
	bist_req_if.sink   req,
	bist_rsp_if.source rsp
);
	import bist_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bist_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_action(req.action), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.sts(sts), .cmd(cmd)
	);

	bist_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.row(req.row), .col(req.col), .pixel_in(req.pixel_in),
		.cmd(cmd), .sts(sts),
		.pixel_out(rsp.pixel_out), .iterations(rsp.iterations)
	);

	// Result must not be overwritten while waiting
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid)
		else $error("result dropped");
	// No request accepted while a thin is running
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.judge || cmd.apply) |-> !req.ready)
		else $error("accepted during thin");
	// Thin ends with count at least one
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.iter_done |=> rsp.iterations != '0)
		else $error("iteration count zero");
endmodule

[tb/tb_top.sv]
// Testbench for the Zhang-Suen skeleton thinning block: pixel loads, thin runs
// and readback are checked against a behavioral image model kept here.
// Depends on bist_pkg, bist_if and binary_image_skeleton_thinning.
module tb_top;
	import bist_pkg::*;

	localparam int STORE_W   = 256;
	localparam int STORE_H   = 256;
	localparam int CYC_LIMIT = 3000000;
	localparam int N_ITEMS   = 1850;

	typedef struct {
		logic        pix;
		logic [15:0] iters;
	} px_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [8:0] cfg_data;

	bist_req_if req_ch ();
	bist_rsp_if rsp_ch ();

	binary_image_skeleton_thinning i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// Image model state
	bit          img_px [STORE_W*STORE_H];
	bit          del_px [STORE_W*STORE_H];
	int unsigned cols_cfg = 256;
	int unsigned rows_cfg = 256;
	logic [15:0] iter_cnt = '0;

	px_result_t pending_px[$];
	int         n_errors = 0;
	int         n_sent = 0;
	int         burst_left = 0;
	int         hold_off = 0;
	int         cycles = 0;

	always #6 clk = ~clk;

	// Cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYC_LIMIT) begin
			$display("binary_image_skeleton_thinning: mismatch");
			$finish;
		end
	end

	task automatic report(input string what, input int got, input int want);
		$display("ERROR %s: got %0d expected %0d", what, got, want);
		n_errors++;
	endtask

	// Neighborhood test on the model image
	function automatic bit zs_delete(input int r, input int c, input bit ph);
		bit nb [8];
		int a;
		int b;
		nb[0] = img_px[(r-1)*STORE_W + c];
		nb[1] = img_px[(r-1)*STORE_W + c+1];
		nb[2] = img_px[r*STORE_W + c+1];
		nb[3] = img_px[(r+1)*STORE_W + c+1];
		nb[4] = img_px[(r+1)*STORE_W + c];
		nb[5] = img_px[(r+1)*STORE_W + c-1];
		nb[6] = img_px[r*STORE_W + c-1];
		nb[7] = img_px[(r-1)*STORE_W + c-1];
		a = 0;
		b = 0;
		for (int k = 0; k < 8; k++) begin
			b += nb[k];
			if (!nb[k] && nb[(k+1)%8]) a++;
		end
		if (!img_px[r*STORE_W + c] || a != 1 || b < 2 || b > 6) return 0;
		if (!ph) return !(nb[0] & nb[2] & nb[4]) && !(nb[2] & nb[4] & nb[6]);
		return !(nb[0] & nb[2] & nb[6]) && !(nb[0] & nb[4] & nb[6]);
	endfunction

	// Thin the model image to convergence
	function automatic void thin_image_model();
		int w;
		int h;
		bit chg;
		w = (cols_cfg > STORE_W) ? STORE_W : cols_cfg;
		h = (rows_cfg > STORE_H) ? STORE_H : rows_cfg;
		iter_cnt = '0;
		do begin
			chg = 0;
			for (int ph = 0; ph < 2; ph++) begin
				if (w >= 3 && h >= 3) begin
					for (int r = 1; r + 1 < h; r++)
						for (int c = 1; c + 1 < w; c++)
							del_px[r*STORE_W + c] = zs_delete(r, c, ph[0]);
					for (int r = 1; r + 1 < h; r++)
						for (int c = 1; c + 1 < w; c++)
							if (del_px[r*STORE_W + c]) begin
								img_px[r*STORE_W + c] = 0;
								chg = 1;
							end
				end
			end
			if (iter_cnt != 16'hFFFF) iter_cnt++;
		end while (chg);
	endfunction

	function automatic void predict_px(input action_t act, input int r, input int c,
			input bit pin);
		px_result_t e;
		e.pix = 1'b0;
		case (act)
			ACT_WRITE: img_px[r*STORE_W + c] = pin;
			ACT_THIN:  thin_image_model();
			ACT_READ:  e.pix = img_px[r*STORE_W + c];
			default:   ;
		endcase
		e.iters = iter_cnt;
		pending_px.insert(pending_px.size(), e);
	endfunction

	// Send one request; sender runs in bursts with random gaps
	task automatic send_px(input action_t act, input int r, input int c, input bit pin);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid    <= 1'b1;
		req_ch.action   <= act;
		req_ch.row      <= r[7:0];
		req_ch.col      <= c[7:0];
		req_ch.pixel_in <= pin;
		do @(posedge clk); while (!req_ch.ready);
		predict_px(act, r, c, pin);
		n_sent++;
	endtask

	// Stop sending and wait for every outstanding result
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_px.size() != 0) @(posedge clk);
	endtask

	task automatic set_dim(input logic [0:0] idx, input int unsigned val);
		drain();
		repeat (40) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[8:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_WIDTH) cols_cfg = val;
		else rows_cfg = val;
	endtask

	// Receiver stall pattern: after any hold-off, cycles through four ready modes by cycle count
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (hold_off > 0) begin
			rsp_ch.ready <= 1'b0;
			hold_off <= hold_off - 1;
		end else begin
			case ((cycles / 64) % 4)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= $urandom_range(0, 1);
				2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
				default: rsp_ch.ready <= (cycles % 5 != 0);
			endcase
		end
	end

	// Result checker
	always @(posedge clk) begin
		px_result_t e;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (pending_px.size() == 0) begin
				report("unexpected result", 0, 0);
			end else begin
				e = pending_px.pop_front();
				if (rsp_ch.pixel_out !== e.pix) report("pixel_out", rsp_ch.pixel_out, e.pix);
				if (rsp_ch.iterations !== e.iters)
					report("iterations", rsp_ch.iterations, e.iters);
			end
		end
	end

	// Corners of the store, unknown action, reads before any thin
	task automatic test_corners();
		send_px(ACT_READ, 0, 0, 0);
		send_px(ACT_NONE, 255, 255, 1);
		send_px(ACT_WRITE, 0, 0, 1);
		send_px(ACT_WRITE, 255, 255, 1);
		send_px(ACT_WRITE, 0, 255, 1);
		send_px(ACT_WRITE, 255, 0, 1);
		send_px(ACT_READ, 255, 255, 0);
		send_px(ACT_READ, 0, 255, 0);
		send_px(ACT_WRITE, 255, 255, 0);
		send_px(ACT_READ, 255, 255, 1);
	endtask

	// Tiny, oversized and extreme dimensions
	task automatic test_dims();
		set_dim(REG_WIDTH, 2);
		set_dim(REG_HEIGHT, 300);
		send_px(ACT_THIN, 0, 0, 0);
		set_dim(REG_WIDTH, 511);
		set_dim(REG_HEIGHT, 3);
		for (int c = 5; c < 9; c++) send_px(ACT_WRITE, 1, c, 1);
		send_px(ACT_THIN, 0, 0, 0);
		send_px(ACT_READ, 1, 6, 0);
		set_dim(REG_WIDTH, 3);
		set_dim(REG_HEIGHT, 256);
		send_px(ACT_WRITE, 1, 1, 1);
		send_px(ACT_THIN, 0, 0, 0);
		set_dim(REG_WIDTH, 0);
		set_dim(REG_HEIGHT, 0);
		send_px(ACT_THIN, 0, 0, 0);
		set_dim(REG_WIDTH, 256);
		set_dim(REG_HEIGHT, 256);
		send_px(ACT_NONE, 0, 0, 0);
	endtask

	// Receiver holds off for a long stretch while writes keep coming; then a thin and readback
	task automatic test_backpressure();
		set_dim(REG_WIDTH, 8);
		set_dim(REG_HEIGHT, 8);
		hold_off = 400;
		for (int i = 0; i < 64; i++) send_px(ACT_WRITE, i / 8, i % 8, (i % 8) > 1);
		drain();
		send_px(ACT_THIN, 0, 0, 0);
		for (int i = 0; i < 8; i++) send_px(ACT_READ, i, 3, 0);
	endtask

	// Random blobs or scattered pixels in randomly sized images, thinned and read back, with noise
	task automatic test_random();
		int w;
		int h;
		int r0;
		int r1;
		int c0;
		int c1;
		int sel;
		while (n_sent < N_ITEMS) begin
			sel = $urandom_range(0, 9);
			if (sel == 0) begin
				w = $urandom_range(0, 2);
				h = $urandom_range(3, 12);
			end else if (sel == 1) begin
				w = 256;
				h = 3;
			end else if (sel == 2) begin
				w = 3;
				h = $urandom_range(200, 511);
			end else begin
				w = $urandom_range(3, 12);
				h = $urandom_range(3, 12);
			end
			set_dim(REG_WIDTH, w);
			set_dim(REG_HEIGHT, h);
			if (w > 256) w = 256;
			if (h > 256) h = 256;
			r0 = $urandom_range(0, 3);
			r1 = r0 + $urandom_range(2, 8);
			c0 = $urandom_range(0, 3);
			c1 = c0 + $urandom_range(2, 8);
			if (w * h <= 150) begin
				for (int r = 0; r < h; r++)
					for (int c = 0; c < w; c++)
						send_px(ACT_WRITE, r, c,
							(r >= r0 && r <= r1 && c >= c0 && c <= c1) ||
							$urandom_range(0, 7) == 0);
			end else begin
				for (int i = 0; i < 40; i++)
					send_px(ACT_WRITE, $urandom_range(0, h - 1), $urandom_range(0, w - 1),
						$urandom_range(0, 3) != 0);
			end
			// Noise anywhere in the store
			for (int i = 0; i < 6; i++)
				send_px(action_t'($urandom_range(0, 3) == 1 ? 3 : $urandom_range(0, 3)),
					$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1));
			send_px(ACT_THIN, $urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 1));
			for (int i = 0; i < 12; i++)
				send_px(ACT_READ, $urandom_range(0, (h < 3 ? 3 : h) - 1),
					$urandom_range(0, (w < 3 ? 3 : w) - 1), 0);
		end
	endtask

	initial begin
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_index       <= '0;
		cfg_data        <= '0;
		req_ch.valid    <= 1'b0;
		req_ch.action   <= ACT_WRITE;
		req_ch.row      <= '0;
		req_ch.col      <= '0;
		req_ch.pixel_in <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corners();
		test_dims();
		test_backpressure();
		test_random();

		drain();
		repeat (100) @(posedge clk);
		if (n_errors == 0) begin
			$display("binary_image_skeleton_thinning: match");
		end else begin
			$display("binary_image_skeleton_thinning: mismatch");
		end
		$finish;
	end
endmodule

[binary_image_skeleton_thinning.f]
sv/bist_pkg.sv
sv/bist_if.sv
sv/bist_ram.sv
sv/bist_ctrl.sv
sv/bist_dp.sv
sv/binary_image_skeleton_thinning.sv
tb/tb_top.sv
